@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker of this project.
// No dependencies; take in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/pcacf_pkg.sv @@
// Shared widths, defaults and register codes of the per-channel average change filter.
// No dependencies; used by the top level and its checker.
package pcacf_pkg;

   // Field widths
   localparam int SENSOR_W = 3;
   localparam int SAMPLE_W = 12;
   localparam int AVG_W    = 16;
   localparam int THRESH_W = 12;

   // Packed stream widths, padded to whole bytes
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   // Parameter defaults
   localparam int NUM_SENSORS_DEFAULT = 8;
   localparam int WINDOW_DEFAULT      = 3;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] REG_DEADBAND = 1'd0;
   localparam logic [THRESH_W-1:0]  THRESH_RESET = 12'd23;

endpackage

@@ rtl/pcacf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pcacf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word; the read word is registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/per_channel_average_change_filter.sv @@
// Per-channel moving average with a change-report deadband: top level.
// Depends on pcacf_pkg and pcacf_ram.
//
// Usage
//   req channel: one transaction carries a sensor number and a 1/16 degC sample.
//   rsp channel: one transaction carries the sensor number and its new window
//     average in 1/256 degC, sent only when the average has moved by more than
//     the deadband register since the last report for that sensor.
//   csr port: deadband register at byte address 0 (reset value 23).
// Sequencing
//   A transaction with an out-of-range sensor number is dropped; req_tready
//   stays high. Any other is taken through the sequencer states record
//   fetch, window sum, rounding prep, reciprocal multiply and compare, back
//   to idle, where the next transaction is taken. The window sum reads the
//   sample RAM one slot a cycle, fill being the number of valid window slots
//   (1..WINDOW).
//   A report raises rsp_tvalid in the same cycle that the sequencer returns
//   to idle.
// Reset clears the slot fill counts, ring positions and reported averages (by
//   per-sensor record valid bits) and the output register, and sets the
//   deadband back to 23.
// A stalled rsp channel holds the report; a new transaction is still taken,
//   and the sequencer waits before loading the next report until it drains.
module per_channel_average_change_filter #(
   parameter int NUM_SENSORS = pcacf_pkg::NUM_SENSORS_DEFAULT,
   parameter int WINDOW      = pcacf_pkg::WINDOW_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: sensor_index [2:0], sample [14:3], zero [15]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pcacf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // rsp_tdata: report_index [2:0], average_value [18:3], zero [23:19]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pcacf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pcacf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pcacf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pcacf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   import pcacf_pkg::*;

   localparam int SEL_W   = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
   localparam int ST_AW   = $clog2(NUM_SENSORS * WINDOW);
   localparam int WP_W    = $clog2(WINDOW);
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
   localparam int MAG_W   = SUM_W + 4;
   localparam int DIFF_W  = AVG_W + 1;
   // Reciprocal scaling: exact floor division for any numerator below 2**MAG_W
   localparam int RSH     = MAG_W + $clog2(WINDOW);
   localparam int RCP_W   = RSH + 1;
   localparam int PROD_W  = MAG_W + RCP_W;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_META = 6'b000010,
      S_SUM  = 6'b000100,
      S_PREP = 6'b001000,
      S_DIV  = 6'b010000,
      S_CMP  = 6'b100000
   } state_type;

   // Per-sensor record kept in the metadata RAM
   typedef struct packed {
      logic [AVG_W-1:0] last;
      logic [WP_W-1:0]  wpos;
      logic [CNT_W-1:0] fill;
   } meta_type;

   // Control registers
   state_type               state_ff, state_in;
   logic [NUM_SENSORS-1:0]  rec_valid_ff, rec_valid_in;
   logic                    pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [THRESH_W-1:0]     threshold_ff, threshold_in;

   // Datapath registers
   logic [SENSOR_W-1:0]     sensor_ff, sensor_in;
   logic [SEL_W-1:0]        sel_ff, sel_in;
   logic [ST_AW-1:0]        base_ff, base_in;
   logic [SAMPLE_W-1:0]     sample_ff, sample_in;
   logic [WP_W-1:0]         wpos_ff, wpos_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [AVG_W-1:0]        last_ff, last_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    neg_ff, neg_in;
   logic [MAG_W-1:0]        div_ff, div_in;
   logic [SENSOR_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [AVG_W-1:0]        rsp_avg_ff, rsp_avg_in;

   // Stream fields
   logic [SENSOR_W-1:0]     req_sensor;
   logic [SAMPLE_W-1:0]     req_sample;
   logic                    in_range;

   // RAM ports
   logic                    st_we;
   logic [ST_AW-1:0]        st_wr_addr;
   logic [ST_AW-1:0]        st_rd_addr;
   logic [SAMPLE_W-1:0]     st_rd_data;
   logic                    meta_we;
   meta_type                meta_wr;
   logic [SEL_W-1:0]        meta_rd_addr;
   logic [$bits(meta_type)-1:0] meta_rd_bits;
   meta_type                meta;

   // Arithmetic
   logic [SUM_W-1:0]        sum_abs;
   logic [MAG_W-1:0]        mag;
   logic [RCP_W-1:0]        recip;
   logic [PROD_W-1:0]       prod;
   logic [AVG_W-1:0]        avg;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]       adiff;
   logic                    report;
   logic                    csr_wr;

   // Reciprocal of a slot count, rounded up (elaboration-time constant)
   function automatic logic [RCP_W-1:0] recip_of(input int c);
      return RCP_W'(((64'd1 << RSH) + 64'(c) - 64'd1) / 64'(c));
   endfunction

   assign req_sensor = req_tdata[SENSOR_W-1:0];
   assign req_sample = req_tdata[SENSOR_W+SAMPLE_W-1:SENSOR_W];
   assign in_range   = 32'(req_sensor) < NUM_SENSORS;

   // Sample ring store, WINDOW slots per sensor
   pcacf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (NUM_SENSORS * WINDOW)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_wr_addr),
      .wr_data (sample_ff),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // Per-sensor record store: last report, ring position, fill count
   pcacf_ram #(
      .WIDTH ($bits(meta_type)),
      .DEPTH (NUM_SENSORS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (sel_ff),
      .wr_data (meta_wr),
      .rd_addr (meta_rd_addr),
      .rd_data (meta_rd_bits)
   );

   // Look the record up while idle, so it is ready in the next state
   assign meta_rd_addr = (state_ff == S_IDLE) ? SEL_W'(req_sensor) : sel_ff;
   assign meta = rec_valid_ff[sel_ff] ? meta_type'(meta_rd_bits) : '0;
   assign st_wr_addr = base_ff + ST_AW'(meta.wpos);
   assign st_rd_addr = base_ff + ST_AW'(k_ff);

   // Rounding numerator: |sum| * 16 plus half the count
   assign sum_abs = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign mag     = {sum_abs, 4'b0000} + MAG_W'(fill_ff >> 1);

   // Pick the reciprocal for the current slot count
   always_comb begin
      recip = '0;
      for (int c = 1; c <= WINDOW; c++) begin
         if (fill_ff == CNT_W'(c)) begin
            recip = recip_of(c);
         end
      end
   end

   // Divide by the count: multiply by its reciprocal
   assign prod = PROD_W'(div_ff) * PROD_W'(recip);

   // Signed average and deadband compare
   assign avg    = neg_ff ? AVG_W'(-div_ff[AVG_W-1:0]) : div_ff[AVG_W-1:0];
   assign diff   = DIFF_W'(signed'(avg)) - DIFF_W'(signed'(last_ff));
   assign adiff  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign report = adiff > DIFF_W'(threshold_ff);

   // Register writes
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready &
                   (csr_paddr[CSR_ADDR_W-1:2] == REG_DEADBAND);
   assign threshold_in = csr_wr ? csr_pwdata[THRESH_W-1:0] : threshold_ff;
   assign csr_prdata   = (csr_paddr[CSR_ADDR_W-1:2] == REG_DEADBAND) ?
                         CSR_DATA_W'(threshold_ff) : '0;
   assign csr_pready   = 1'b1;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      rec_valid_in = rec_valid_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      sensor_in    = sensor_ff;
      sel_in       = sel_ff;
      base_in      = base_ff;
      sample_in    = sample_ff;
      wpos_in      = wpos_ff;
      fill_in      = fill_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      sum_in       = sum_ff;
      neg_in       = neg_ff;
      div_in       = div_ff;
      rsp_index_in = rsp_index_ff;
      rsp_avg_in   = rsp_avg_ff;
      st_we        = 1'b0;
      meta_we      = 1'b0;
      meta_wr      = '0;

      // Drain the output register
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            // Take a transaction; drop it if the sensor is out of range
            if (req_tvalid && in_range) begin
               sensor_in = req_sensor;
               sel_in    = SEL_W'(req_sensor);
               base_in   = ST_AW'(32'(req_sensor) * WINDOW);
               sample_in = req_sample;
               state_in  = S_META;
            end
         end
         S_META: begin
            // Store the sample, advance the ring position and the fill count
            st_we   = 1'b1;
            wpos_in = (meta.wpos == WP_W'(WINDOW - 1)) ? '0 : meta.wpos + 1'b1;
            fill_in = (meta.fill == CNT_W'(WINDOW)) ? meta.fill : meta.fill + 1'b1;
            last_in = meta.last;
            k_in    = '0;
            pend_in = 1'b0;
            sum_in  = '0;
            state_in = S_SUM;
         end
         S_SUM: begin
            // Read one valid slot a cycle, add the one read before
            if (pend_ff) begin
               sum_in = sum_ff + SUM_W'(signed'(st_rd_data));
            end
            if (k_ff < fill_ff) begin
               k_in    = k_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            neg_in   = sum_ff[SUM_W-1];
            div_in   = mag;
            state_in = S_DIV;
         end
         S_DIV: begin
            // Keep the quotient of the rounded magnitude
            div_in   = MAG_W'(prod >> RSH);
            state_in = S_CMP;
         end
         S_CMP: begin
            // Hold while a report is due and the output is still full
            if (!(report && rsp_valid_ff && !rsp_tready)) begin
               meta_we      = 1'b1;
               meta_wr.last = report ? avg : last_ff;
               meta_wr.wpos = wpos_ff;
               meta_wr.fill = fill_ff;
               rec_valid_in[sel_ff] = 1'b1;
               if (report) begin
                  rsp_valid_in = 1'b1;
                  rsp_index_in = sensor_ff;
                  rsp_avg_in   = avg;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rec_valid_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= THRESH_RESET;
      end else begin
         state_ff     <= state_in;
         rec_valid_ff <= rec_valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         threshold_ff <= threshold_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      sensor_ff    <= sensor_in;
      sel_ff       <= sel_in;
      base_ff      <= base_in;
      sample_ff    <= sample_in;
      wpos_ff      <= wpos_in;
      fill_ff      <= fill_in;
      last_ff      <= last_in;
      k_ff         <= k_in;
      sum_ff       <= sum_in;
      neg_ff       <= neg_in;
      div_ff       <= div_in;
      rsp_index_ff <= rsp_index_in;
      rsp_avg_ff   <= rsp_avg_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - AVG_W - SENSOR_W)'(0), rsp_avg_ff, rsp_index_ff};

endmodule

@@ rtl/pcacf_checker.sv @@
// Port-level checks of the per-channel average change filter, and their bind.
// Depends on pcacf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcacf_checker #(
   parameter int NUM_SENSORS = pcacf_pkg::NUM_SENSORS_DEFAULT
) (
   input logic                               clock,
   input logic                               reset,
   // req_tdata: sensor_index [2:0], sample [14:3], zero [15]
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [pcacf_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // rsp_tdata: report_index [2:0], average_value [18:3], zero [23:19]
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [pcacf_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   import pcacf_pkg::*;

   // A stalled report holds its value
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled report changed")

   // An in-range transaction keeps the sequencer busy for the next cycle
   `ASSERT_NEXT(a_busy_after_take, clock, reset, req_tvalid && req_tready && (32'(req_tdata[SENSOR_W-1:0]) < NUM_SENSORS), !req_tready, "ready right after an in-range transaction")

   // A new report appears as the sequencer returns to idle
   `ASSERT_SAME(a_report_at_idle, clock, reset, $rose(rsp_tvalid), req_tready, "report raised while busy")

   // Reports only name existing sensors
   `ASSERT_SAME(a_report_index, clock, reset, rsp_tvalid, 32'(rsp_tdata[SENSOR_W-1:0]) < NUM_SENSORS, "report for a missing sensor")

endmodule

bind per_channel_average_change_filter pcacf_checker #(
   .NUM_SENSORS (NUM_SENSORS)
) u_pcacf_checker (.*);

@@ tb/per_channel_average_change_filter_tb.sv @@
// Self-checking testbench for the per-channel average change filter.
// Depends on pcacf_pkg and the filter RTL; predicts each report and checks it
// against the rsp stream while both stream sides idle and stall at random.
`timescale 1ns / 100ps

module per_channel_average_change_filter_tb;
   import pcacf_pkg::*;

   localparam int SENSORS       = NUM_SENSORS_DEFAULT;
   localparam int RING_DEPTH    = WINDOW_DEFAULT;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 300;
   localparam logic [CSR_IDX_W:0] UNUSED_REG = 2'd1;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 12'sh7FF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 12'sh800;

   typedef struct {
      logic [SENSOR_W-1:0]      sensor;
      logic signed [AVG_W-1:0]  average;
   } report_type;

   typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PERIODIC} ready_mode_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata;   // sensor_index [2:0], sample [14:3], zero [15]
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;   // report_index [2:0], average_value [18:3], zero [23:19]
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_W-1:0]    csr_paddr;
   logic [CSR_DATA_W-1:0]    csr_pwdata;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   // Predictor state
   logic [THRESH_W-1:0]      threshold_now;
   logic signed [SAMPLE_W-1:0] ring_sample [SENSORS][RING_DEPTH];
   logic                     ring_valid [SENSORS][RING_DEPTH];
   int                       ring_pos [SENSORS];
   int                       reported_avg [SENSORS];
   report_type               pending_reports [$];

   // Run bookkeeping
   int error_count;
   int samples_sent;
   int reports_seen;
   int settings_used;
   int burst_left;
   int hold_request;
   int hold_left;
   int mode_span;
   ready_mode_type ready_mode;
   logic [SENSOR_W-1:0] last_sensor;
   int near_base [SENSORS];

   per_channel_average_change_filter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Count and print one mismatch
   task automatic flag_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // Clear the predictor as reset does
   task automatic clear_filter_model();
      threshold_now = THRESH_RESET;
      for (int s = 0; s < SENSORS; s++) begin
         ring_pos[s]     = 0;
         reported_avg[s] = 0;
         for (int k = 0; k < RING_DEPTH; k++) begin
            ring_sample[s][k] = '0;
            ring_valid[s][k]  = 1'b0;
         end
      end
   endtask

   // Store the sample, average the ring and queue a report if it moved enough
   task automatic update_sensor_average(input logic [SENSOR_W-1:0] sensor,
                                        input logic signed [SAMPLE_W-1:0] sample);
      int sum;
      int cnt;
      int num;
      int mag;
      int quot;
      int avg;
      int delta;
      report_type rep;
      sum = 0;
      cnt = 0;
      ring_sample[sensor][ring_pos[sensor]] = sample;
      ring_valid[sensor][ring_pos[sensor]]  = 1'b1;
      ring_pos[sensor] = (ring_pos[sensor] + 1) % RING_DEPTH;
      for (int k = 0; k < RING_DEPTH; k++) begin
         if (ring_valid[sensor][k]) begin
            sum += int'(ring_sample[sensor][k]);
            cnt++;
         end
      end
      // Round to nearest, ties away from zero
      num  = sum * 16;
      mag  = (num < 0) ? -num : num;
      quot = (mag + cnt / 2) / cnt;
      avg  = (num < 0) ? -quot : quot;
      delta = avg - reported_avg[sensor];
      if (delta < 0) delta = -delta;
      if (delta > int'(threshold_now)) begin
         reported_avg[sensor] = avg;
         rep.sensor  = sensor;
         rep.average = avg[AVG_W-1:0];
         pending_reports.push_back(rep);
      end
   endtask

   // Offer one sample transaction and hold it until accepted
   task automatic send_sample(input logic [SENSOR_W-1:0] sensor,
                              input logic signed [SAMPLE_W-1:0] sample);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, sample, sensor};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      update_sensor_average(sensor, sample);
      samples_sent++;
      last_sensor = sensor;
   endtask

   // Burst pacing: drop valid for a random gap once a burst runs out
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
      end
      burst_left--;
   endtask

   // Idle the sender until every report is in, then let the block settle
   task automatic wait_until_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle
   task automatic csr_write(input logic [CSR_IDX_W:0] index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(index) << 2;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (index == REG_DEADBAND) threshold_now = value[THRESH_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Read the threshold back and compare
   task automatic csr_check_threshold();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(REG_DEADBAND) << 2;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(threshold_now))
         flag_mismatch("deadband readback", int'(csr_prdata), int'(threshold_now));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_threshold(input int value);
      csr_write(REG_DEADBAND, CSR_DATA_W'(value));
      csr_check_threshold();
      settings_used++;
   endtask

   // Mix of full-range, in-range, near-steady and extreme samples
   task automatic pick_sample(output logic [SENSOR_W-1:0] sensor,
                              output logic signed [SAMPLE_W-1:0] sample);
      int pick;
      int value;
      pick   = $urandom_range(0, 9);
      sensor = ($urandom_range(0, 3) == 0) ? last_sensor : SENSOR_W'($urandom_range(0, 7));
      if (pick < 2)
         value = $urandom_range(0, 4095) - 2048;
      else if (pick < 5)
         value = $urandom_range(0, 2880) - 880;
      else if (pick < 9)
         value = near_base[sensor] + $urandom_range(0, 8) - 4;
      else
         value = $urandom_range(0, 1) ? int'(SAMPLE_MAX) : int'(SAMPLE_MIN);
      sample = value[SAMPLE_W-1:0];
   endtask

   // Receiver: random stall patterns, plus a counted long hold-off on request
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (mode_span == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_span  = $urandom_range(16, 96);
      end
      mode_span--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (ready_mode)
            READY_ALWAYS:   rsp_tready <= 1'b1;
            READY_HALF:     rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
            default:        rsp_tready <= mode_span[2];
         endcase
      end
   end

   // Compare each report transaction with the oldest prediction
   always @(posedge clock) begin
      report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         reports_seen++;
         if (pending_reports.size() == 0) begin
            flag_mismatch("report with none predicted, sensor", int'(rsp_tdata[2:0]), -1);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tdata[2:0] !== want.sensor)
               flag_mismatch("report_index", int'(rsp_tdata[2:0]), int'(want.sensor));
            if (rsp_tdata[18:3] !== want.average)
               flag_mismatch("average_value", int'($signed(rsp_tdata[18:3])),
                             int'(want.average));
            if (rsp_tdata[23:19] !== '0)
               flag_mismatch("rsp_tdata padding", int'(rsp_tdata[23:19]), 0);
         end
      end
   end

   // Reset value, unknown register, extremes of the threshold
   task automatic test_register_access();
      csr_check_threshold();
      csr_write(UNUSED_REG, 32'h0000_0FFF);
      csr_check_threshold();
      set_threshold(4095);
      set_threshold(0);
   endtask

   // Extreme samples, rounding of both signs, ring wrap and the deadband edge
   task automatic test_directed_cases();
      set_threshold(0);
      send_sample(3'd0, SAMPLE_MIN);
      send_sample(3'd7, SAMPLE_MAX);
      send_sample(3'd1, 12'sd1);
      send_sample(3'd1, 12'sd0);
      send_sample(3'd1, 12'sd0);
      send_sample(3'd1, 12'sd0);
      send_sample(3'd1, 12'sd0);
      send_sample(3'd2, -12'sd1);
      send_sample(3'd2, 12'sd0);
      send_sample(3'd2, 12'sd0);
      send_sample(3'd2, -12'sd1);
      send_sample(3'd3, SAMPLE_MIN);
      send_sample(3'd3, SAMPLE_MIN);
      send_sample(3'd3, SAMPLE_MIN);
      send_sample(3'd5, SAMPLE_MAX);
      send_sample(3'd5, SAMPLE_MAX);
      send_sample(3'd5, SAMPLE_MAX);
      wait_until_quiet();
      // Change equal to the threshold stays silent, a larger change reports
      set_threshold(16);
      send_sample(3'd6, 12'sd1);
      send_sample(3'd6, 12'sd1);
      send_sample(3'd6, 12'sd1);
      send_sample(3'd6, 12'sd2);
      send_sample(3'd4, 12'sd1);
      send_sample(3'd4, 12'sd2);
      wait_until_quiet();
   endtask

   // One random phase under a given threshold
   task automatic test_random_phase(input int threshold, input int count);
      logic [SENSOR_W-1:0] sensor;
      logic signed [SAMPLE_W-1:0] sample;
      set_threshold(threshold);
      for (int n = 0; n < count; n++) begin
         pace_sender();
         pick_sample(sensor, sample);
         send_sample(sensor, sample);
      end
      wait_until_quiet();
   endtask

   // Hold the result side off while samples keep coming, then drain fully
   task automatic test_backpressure();
      logic [SENSOR_W-1:0] sensor;
      logic signed [SAMPLE_W-1:0] sample;
      set_threshold(0);
      hold_request = LONG_HOLD;
      for (int n = 0; n < 16; n++) begin
         pick_sample(sensor, sample);
         send_sample(SENSOR_W'(n), sample);
      end
      wait_until_quiet();
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      error_count  = 0;
      samples_sent = 0;
      reports_seen = 0;
      settings_used = 0;
      burst_left   = 0;
      hold_request = 0;
      hold_left    = 0;
      mode_span    = 0;
      ready_mode   = READY_ALWAYS;
      last_sensor  = '0;
      for (int s = 0; s < SENSORS; s++) near_base[s] = $urandom_range(0, 2880) - 880;
      clear_filter_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_access();
      test_directed_cases();
      test_random_phase(0, 150);
      test_backpressure();
      test_random_phase(4095, 80);
      test_random_phase($urandom_range(1, 64), 120);
      test_random_phase(THRESH_RESET, 100);
      test_random_phase($urandom_range(0, 4095), 50);
      wait_until_quiet();

      $display("Sent %0d sample transactions and checked %0d reports over %0d threshold settings,",
               samples_sent, reports_seen, settings_used);
      $display("with random stream stalls and a %0d-cycle result-side hold-off.", LONG_HOLD);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #6_000_000;
      $display("Timeout with %0d reports still predicted", pending_reports.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
